// File: sv/mcpwm_pkg.sv
package mcpwm_pkg;

	localparam int OP_W       = 2;
	localparam int UNIT_W     = 3;
	localparam int VALUE_W    = 19;
	localparam int STATUS_W   = 3;
	localparam int PIN_W      = 8;
	localparam int MF_W       = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 19;

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_FREQ = 2'd1;
	localparam logic [OP_W-1:0] OP_DUTY = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_CLAMP = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOCFG = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RES  = 1'd1;

	localparam int FREQ_LIMIT    = 10000;
	localparam int PRODUCT_LIMIT = 500000;
	localparam int FALLBACK_FREQ = 500;
	localparam int FALLBACK_RES  = 100;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int DIV_STEPS = VALUE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_FREQ,
		CMD_DUTY,
		CMD_BAD,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [UNIT_W-1:0]   unit;
		logic [VALUE_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] num;
		logic [VALUE_W-1:0] den;
	} div_req_t;

endpackage

// File: sv/mcpwm_if.sv
interface mcpwm_cmd_if;
	import mcpwm_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [UNIT_W-1:0]  unit;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output opcode, output unit, output value, input ready);
	modport sink (input valid, input opcode, input unit, input value, output ready);
endinterface

interface mcpwm_rsp_if;
	import mcpwm_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PIN_W-1:0]    pin_levels;
	logic [VALUE_W-1:0]  period_ticks;

	modport source (output valid, output status, output pin_levels, output period_ticks,
		input ready);
	modport sink (input valid, input status, input pin_levels, input period_ticks,
		output ready);
endinterface

// File: sv/multi_channel_pwm_generator_unit.sv
// channel  dir  handshake     payload
// cmd      in   valid/ready   opcode[1:0] unit[2:0] value[18:0]
// rsp      out  valid/ready   status[2:0] pin_levels[7:0] period_ticks[18:0]
// cfg      in   cfg_we        cfg_index[0] cfg_data[18:0]
//
// Tick, set-duty, no-op and rejected items: an accepted cmd is written into the
// queue, and rsp.valid is registered when the item is taken from the queue head.
// Set-frequency: the issue step starts the bit-serial divider, and a finish step
// registers the period and rsp.valid. A stalled rsp holds back issue and finish.
// Reset clears all generator state at once; there is no clearing pass.
// A two-entry queue lets cmd keep accepting while rsp is stalled.
module multi_channel_pwm_generator_unit #(
	parameter int GENERATOR_COUNT = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mcpwm_cmd_if.sink                           cmd,
	mcpwm_rsp_if.source                         rsp,
	input  logic                                cfg_we,
	input  logic [mcpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcpwm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mcpwm_pkg::*;

	q_head_t            head;
	logic               pop;
	div_req_t           div_req;
	logic               div_done;
	logic [VALUE_W-1:0] div_quot;

	mcpwm_front #(
		.GENERATOR_COUNT(GENERATOR_COUNT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head),
		.pop    (pop)
	);

	mcpwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	mcpwm_back #(
		.GENERATOR_COUNT(GENERATOR_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.div_req   (div_req),
		.div_done  (div_done),
		.div_quot  (div_quot),
		.rsp       (rsp)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

	a_div_start_freq: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (pop && head.cmd.kind == CMD_FREQ))
		else $error("divider started without a set-frequency transaction");

	a_div_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_done)
		else $error("divider done right after start");

	a_err_no_period: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STAT_OK && rsp.status != STAT_CLAMP)
		|-> rsp.period_ticks == '0)
		else $error("error status with nonzero period");

endmodule

// File: sv/mcpwm_front.sv
module mcpwm_front #(
	parameter int GENERATOR_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	mcpwm_cmd_if.sink         cmd,
	output mcpwm_pkg::q_head_t head,
	input  logic              pop
);
	import mcpwm_pkg::*;

	cmd_t              q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   fill_q;
	cmd_t              cls;
	logic              push;

	assign cmd.ready = fill_q < (QPTR_W + 1)'(QUEUE_DEPTH);
	assign push      = cmd.valid && cmd.ready;

	always_comb begin
		cls.unit  = cmd.unit;
		cls.value = cmd.value;
		unique case (cmd.opcode)
			OP_TICK: cls.kind = CMD_TICK;
			OP_FREQ: cls.kind = (32'(cmd.unit) < GENERATOR_COUNT) ? CMD_FREQ : CMD_BAD;
			OP_DUTY: cls.kind = (32'(cmd.unit) < 2 * GENERATOR_COUNT) ? CMD_DUTY : CMD_BAD;
			OP_NOP:  cls.kind = CMD_NOP;
		endcase
	end

	assign head.valid = fill_q != '0;
	assign head.cmd   = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/mcpwm_div.sv
module mcpwm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mcpwm_pkg::div_req_t               req,
	output logic                              done,
	output logic [mcpwm_pkg::VALUE_W-1:0]     quot
);
	import mcpwm_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [VALUE_W-1:0]   rem_q;
	logic [VALUE_W-1:0]   quo_q;
	logic [VALUE_W-1:0]   den_q;
	logic [VALUE_W:0]     trial;
	logic [VALUE_W:0]     diff;
	logic                 fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[VALUE_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign done  = cnt_q == '0;
	assign quot  = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
			quo_q <= {quo_q[VALUE_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: sv/mcpwm_back.sv
module mcpwm_back #(
	parameter int GENERATOR_COUNT = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcpwm_pkg::q_head_t                  head,
	output logic                                pop,
	input  logic                                cfg_we,
	input  logic [mcpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcpwm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output mcpwm_pkg::div_req_t                 div_req,
	input  logic                                div_done,
	input  logic [mcpwm_pkg::VALUE_W-1:0]       div_quot,
	mcpwm_rsp_if.source                         rsp
);
	import mcpwm_pkg::*;

	localparam int CH = 2 * GENERATOR_COUNT;
	localparam int GW = (GENERATOR_COUNT > 1) ? $clog2(GENERATOR_COUNT) : 1;
	localparam int CW = $clog2(CH);
	localparam int PW = (CH > PIN_W) ? CH : PIN_W;
	localparam int PROD_W = MF_W + VALUE_W;

	typedef enum logic {S_IDLE, S_DIV} state_t;

	state_t                   state_q;
	logic [VALUE_W-1:0]       cnt_q [GENERATOR_COUNT];
	logic [VALUE_W-1:0]       per_q [GENERATOR_COUNT];
	logic [GENERATOR_COUNT-1:0] conf_q;
	logic [VALUE_W-1:0]       duty_q [CH];
	logic [PIN_W-1:0]         pin_q;
	logic [MF_W-1:0]          freq_cap_q;
	logic [VALUE_W-1:0]       min_res_q;
	logic [MF_W-1:0]          eff_mf_q;
	logic [VALUE_W-1:0]       eff_num_q;
	logic [GW-1:0]            div_gen_q;
	logic                     rsp_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic [PIN_W-1:0]         pins_out_q;
	logic [VALUE_W-1:0]       period_out_q;

	logic [PROD_W-1:0]        prod;
	logic                     limits_ok;
	logic [PW-1:0]            tick_pins;
	logic [VALUE_W:0]         tick_inc [GENERATOR_COUNT];
	logic [VALUE_W-1:0]       tick_cnt [GENERATOR_COUNT];
	logic [GW-1:0]            h_gen;
	logic [CW-1:0]            h_ch;
	logic [GW-1:0]            h_ch_gen;
	logic [VALUE_W-1:0]       h_value;
	logic                     freq_bad;
	logic                     out_free;
	logic                     go;
	logic                     div_finish;

	assign prod      = freq_cap_q * min_res_q;
	assign limits_ok = (freq_cap_q != '0) && (freq_cap_q < MF_W'(FREQ_LIMIT))
		&& (min_res_q != '0) && (prod <= PROD_W'(PRODUCT_LIMIT));

	always_comb begin
		tick_pins = '0;
		for (int g = 0; g < GENERATOR_COUNT; g++) begin
			tick_inc[g] = {1'b0, cnt_q[g]} + 1'b1;
			tick_cnt[g] = cnt_q[g];
			if (conf_q[g]) begin
				tick_pins[2*g]   = cnt_q[g] < duty_q[2*g];
				tick_pins[2*g+1] = cnt_q[g] < duty_q[2*g+1];
				tick_cnt[g] = (tick_inc[g] >= {1'b0, per_q[g]}) ? '0 : tick_inc[g][VALUE_W-1:0];
			end
		end
	end

	assign h_gen    = GW'(head.cmd.unit);
	assign h_ch     = CW'(head.cmd.unit);
	assign h_ch_gen = GW'(h_ch >> 1);
	assign h_value  = head.cmd.value;
	assign freq_bad = (h_value == '0) || (h_value > VALUE_W'(eff_mf_q));

	assign out_free   = !rsp_valid_q || rsp.ready;
	assign go         = (state_q == S_IDLE) && head.valid && out_free;
	assign pop        = go;
	assign div_finish = (state_q == S_DIV) && div_done && out_free;

	assign div_req.start = go && (head.cmd.kind == CMD_FREQ) && !freq_bad;
	assign div_req.num   = eff_num_q;
	assign div_req.den   = h_value;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.pin_levels   = pins_out_q;
	assign rsp.period_ticks = period_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '{default: '0};
			per_q        <= '{default: '0};
			conf_q       <= '0;
			duty_q       <= '{default: '0};
			pin_q        <= '0;
			freq_cap_q   <= MF_W'(FALLBACK_FREQ);
			min_res_q    <= VALUE_W'(FALLBACK_RES);
			eff_mf_q     <= MF_W'(FALLBACK_FREQ);
			eff_num_q    <= VALUE_W'(FALLBACK_FREQ * FALLBACK_RES);
			div_gen_q    <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= STAT_OK;
			pins_out_q   <= '0;
			period_out_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_FREQ: freq_cap_q <= cfg_data[MF_W-1:0];
					REG_MIN_RES:  min_res_q  <= cfg_data;
				endcase
			end
			eff_mf_q  <= limits_ok ? freq_cap_q : MF_W'(FALLBACK_FREQ);
			eff_num_q <= limits_ok ? prod[VALUE_W-1:0] : VALUE_W'(FALLBACK_FREQ * FALLBACK_RES);

			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						rsp_valid_q  <= !div_req.start;
						status_q     <= STAT_OK;
						pins_out_q   <= pin_q;
						period_out_q <= '0;
						unique case (head.cmd.kind)
							CMD_TICK: begin
								cnt_q      <= tick_cnt;
								pin_q      <= tick_pins[PIN_W-1:0];
								pins_out_q <= tick_pins[PIN_W-1:0];
							end
							CMD_FREQ: begin
								cnt_q[h_gen] <= '0;
								for (int c = 0; c < CH; c++) begin
									if (GW'(c / 2) == h_gen) begin
										duty_q[c] <= '0;
									end
								end
								if (freq_bad) begin
									conf_q[h_gen] <= 1'b0;
									per_q[h_gen]  <= '0;
									status_q      <= STAT_RANGE;
								end else begin
									div_gen_q <= h_gen;
									state_q   <= S_DIV;
								end
							end
							CMD_DUTY: begin
								if (!conf_q[h_ch_gen]) begin
									status_q <= STAT_NOCFG;
								end else begin
									period_out_q <= per_q[h_ch_gen];
									if (h_value >= per_q[h_ch_gen]) begin
										duty_q[h_ch] <= per_q[h_ch_gen];
										status_q     <= STAT_CLAMP;
									end else begin
										duty_q[h_ch] <= h_value;
									end
								end
							end
							CMD_BAD: status_q <= STAT_BAD;
							CMD_NOP: status_q <= STAT_OK;
							default: status_q <= STAT_OK;
						endcase
					end
				end
				S_DIV: begin
					if (div_finish) begin
						per_q[div_gen_q]  <= div_quot;
						conf_q[div_gen_q] <= 1'b1;
						rsp_valid_q       <= 1'b1;
						status_q          <= STAT_OK;
						pins_out_q        <= pin_q;
						period_out_q      <= div_quot;
						state_q           <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule
